FILE: sv/hds_pkg.sv
package hds_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_ROWS_DEF    = 64;
    localparam int MAX_COLS_DEF    = 64;
    localparam int VALUE_WIDTH_DEF = 32;

    // Request codes.
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_RUN   = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_GRID_ROWS  = 3'd0;
    localparam logic [2:0] CFG_GRID_COLS  = 3'd1;
    localparam logic [2:0] CFG_COEF_X     = 3'd2;
    localparam logic [2:0] CFG_COEF_Y     = 3'd3;
    localparam logic [2:0] CFG_STEP_COUNT = 3'd4;

    // Register reset values.
    localparam logic [6:0]  GRID_ROWS_RST  = 7'd64;
    localparam logic [6:0]  GRID_COLS_RST  = 7'd64;
    localparam logic [15:0] COEF_X_RST     = 16'd16384;
    localparam logic [15:0] COEF_Y_RST     = 16'd16384;
    localparam logic [15:0] STEP_COUNT_RST = 16'd17;

endpackage

FILE: sv/heat_diffusion_stencil_2d.sv
// Five-point explicit heat diffusion engine on a grid of signed Q16.16 cells.
// Requests arrive as words on the input channel (valid/ready): a write stores
// one cell of the current grid, a read returns one cell of it, and a run
// performs step_count diffusion timesteps. Every request gives exactly one
// result word on the output channel (valid/ready); a read or write whose row or
// column lies outside the grid in use gives status 1 and read value zero.
// Configuration registers are written through their own valid/ready channel,
// which is always ready; write them only while the engine is idle.
// Timing: a write or an unused request code gives its result in the cycle
// after acceptance; a read first passes through S_READ and the registered
// memory read. A run is paced by the single read port of each grid memory:
// an interior cell needs five reads and a write, a border cell one read and
// one write.
// One request is processed at a time; the input is ready again once the work
// is done and the output register is empty or being emptied in that cycle.
// If the receiver stalls, the result word holds and no new request is taken.
// Reset clears control state and the configuration registers; the two grid
// memories are not cleared and hold no defined value until written.
module heat_diffusion_stencil_2d #(
    parameter int MAX_ROWS    = hds_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS    = hds_pkg::MAX_COLS_DEF,
    parameter int VALUE_WIDTH = hds_pkg::VALUE_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_req_type,
    input  logic [5:0]         i_row,
    input  logic [5:0]         i_col,
    input  logic signed [31:0] i_cell_value,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_read_value,
    output logic               o_status,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    localparam int VW    = VALUE_WIDTH;
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int NRW   = $clog2(MAX_ROWS + 1);
    localparam int NCW   = $clog2(MAX_COLS + 1);
    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int LW    = VW + 2;   // Laplacian width
    localparam int PW    = LW + 17;  // coefficient product width
    localparam int SW    = PW + 1;   // update sum width

    localparam logic signed [SW-1:0] VMAX = {{(SW - VW + 1){1'b0}}, {(VW - 1){1'b1}}};
    localparam logic signed [SW-1:0] VMIN = ~VMAX;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_INT,
        S_BORD,
        S_STEP_END
    } t_state;

    function automatic logic [AW-1:0] addr(input logic [RW-1:0] ri, input logic [CW-1:0] cj);
        return AW'(AW'(ri) * AW'(MAX_COLS)) + AW'(cj);
    endfunction

    function automatic logic signed [VW-1:0] sat(input logic signed [SW-1:0] v);
        if (v > VMAX) begin
            return VW'(VMAX);
        end else if (v < VMIN) begin
            return VW'(VMIN);
        end
        return VW'(v);
    endfunction

    // Configuration registers.
    logic [6:0]  r_grid_rows;
    logic [6:0]  r_grid_cols;
    logic [15:0] r_coef_x;
    logic [15:0] r_coef_y;
    logic [15:0] r_step_count;

    // Sequencer state.
    t_state         r_state;
    logic           r_bank;
    logic [RW-1:0]  r_i;
    logic [CW-1:0]  r_j;
    logic [2:0]     r_ph;
    logic [1:0]     r_side;
    logic [15:0]    r_steps;
    logic           r_out_valid;
    logic signed [31:0] r_read_value;
    logic           r_status;

    // Datapath registers.
    logic signed [VW-1:0] r_w;
    logic signed [VW-1:0] r_c;
    logic signed [VW-1:0] r_n;
    logic signed [PW-1:0] r_px;
    logic signed [PW-1:0] r_py;

    // Grid memories.
    logic signed [VW-1:0] mem0 [DEPTH];
    logic signed [VW-1:0] mem1 [DEPTH];
    logic signed [VW-1:0] r_rdata0;
    logic signed [VW-1:0] r_rdata1;
    logic                 r_rd_bank;

    logic [NRW-1:0] nr;
    logic [NCW-1:0] nc;
    logic [RW-1:0]  nr_m1, nr_m2;
    logic [CW-1:0]  nc_m1, nc_m2;
    logic           in_fire;
    logic           addr_ok;
    logic signed [VW-1:0] rd_data;
    logic [AW-1:0]  rd_addr;
    logic           rd_bank;
    logic           wr_en;
    logic           wr_bank;
    logic [AW-1:0]  wr_addr;
    logic signed [VW-1:0] wr_data;
    logic           src_cur;
    logic [RW-1:0]  src_i;
    logic [CW-1:0]  src_j;
    logic signed [LW-1:0] lap_x, lap_y;
    logic signed [SW-1:0] upd;

    // Rows and columns in use, clamped to [3, MAX].
    always_comb begin
        if (r_grid_rows < 7'd3) begin
            nr = NRW'(3);
        end else if (32'(r_grid_rows) > 32'(MAX_ROWS)) begin
            nr = NRW'(MAX_ROWS);
        end else begin
            nr = NRW'(r_grid_rows);
        end
        if (r_grid_cols < 7'd3) begin
            nc = NCW'(3);
        end else if (32'(r_grid_cols) > 32'(MAX_COLS)) begin
            nc = NCW'(MAX_COLS);
        end else begin
            nc = NCW'(r_grid_cols);
        end
    end

    assign nr_m1 = RW'(nr - NRW'(1));
    assign nr_m2 = RW'(nr - NRW'(2));
    assign nc_m1 = CW'(nc - NCW'(1));
    assign nc_m2 = CW'(nc - NCW'(2));

    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign addr_ok     = (32'(i_row) < 32'(nr)) && (32'(i_col) < 32'(nc));
    assign rd_data     = r_rd_bank ? r_rdata1 : r_rdata0;

    assign lap_x = LW'(r_w) - (LW'(r_c) <<< 1) + LW'(rd_data);
    assign lap_y = LW'(r_n) - (LW'(r_c) <<< 1) + LW'(rd_data);
    assign upd   = SW'(r_c) + SW'(r_px >>> 16) + SW'(r_py >>> 16);

    // Source of each border cell, following the edge copy order: top, bottom,
    // left, right. Corners pick up whatever their edge saw at copy time.
    always_comb begin
        src_cur = 1'b0;
        src_i   = r_i;
        src_j   = r_j;
        case (r_side)
            2'd0: begin
                if (r_j == '0) begin
                    src_cur = 1'b1;
                    src_i   = '0;
                    src_j   = '0;
                end else if (r_j == nc_m1) begin
                    src_cur = 1'b1;
                    src_i   = RW'(1);
                    src_j   = nc_m1;
                end else begin
                    src_i = RW'(1);
                end
            end
            2'd1: begin
                if (r_j == '0) begin
                    src_cur = 1'b1;
                    src_i   = nr_m1;
                    src_j   = CW'(1);
                end else if (r_j == nc_m1) begin
                    src_i = nr_m2;
                    src_j = nc_m2;
                end else begin
                    src_i = nr_m2;
                end
            end
            2'd2: begin
                src_j = CW'(1);
            end
            default: begin
                src_j = nc_m2;
            end
        endcase
    end

    // Memory port selection.
    always_comb begin
        rd_addr = addr(RW'(i_row), CW'(i_col));
        rd_bank = r_bank;
        wr_en   = 1'b0;
        wr_bank = r_bank;
        wr_addr = addr(RW'(i_row), CW'(i_col));
        wr_data = sat(SW'(i_cell_value));
        case (r_state)
            S_IDLE: begin
                wr_en = in_fire && (i_req_type == hds_pkg::REQ_WRITE) && addr_ok;
            end
            S_INT: begin
                case (r_ph)
                    3'd0:    rd_addr = addr(r_i, CW'(r_j - CW'(1)));
                    3'd1:    rd_addr = addr(r_i, r_j);
                    3'd2:    rd_addr = addr(r_i, CW'(r_j + CW'(1)));
                    3'd3:    rd_addr = addr(RW'(r_i - RW'(1)), r_j);
                    3'd4:    rd_addr = addr(RW'(r_i + RW'(1)), r_j);
                    default: rd_addr = addr(r_i, r_j);
                endcase
                wr_en   = (r_ph == 3'd6);
                wr_bank = ~r_bank;
                wr_addr = addr(r_i, r_j);
                wr_data = sat(upd);
            end
            S_BORD: begin
                rd_addr = addr(src_i, src_j);
                rd_bank = src_cur ? r_bank : ~r_bank;
                wr_en   = (r_ph == 3'd1);
                wr_bank = ~r_bank;
                wr_addr = addr(r_i, r_j);
                wr_data = rd_data;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en && !wr_bank) begin
            mem0[wr_addr] <= wr_data;
        end
        if (wr_en && wr_bank) begin
            mem1[wr_addr] <= wr_data;
        end
        r_rdata0  <= mem0[rd_addr];
        r_rdata1  <= mem1[rd_addr];
        r_rd_bank <= rd_bank;
    end

    // Datapath captures during the interior cell phases.
    always_ff @(posedge i_clk) begin
        if (r_state == S_INT) begin
            case (r_ph)
                3'd1: r_w <= rd_data;
                3'd2: r_c <= rd_data;
                3'd3: r_px <= PW'(lap_x) * PW'(signed'({1'b0, r_coef_x}));
                3'd4: r_n <= rd_data;
                3'd5: r_py <= PW'(lap_y) * PW'(signed'({1'b0, r_coef_y}));
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows  <= hds_pkg::GRID_ROWS_RST;
            r_grid_cols  <= hds_pkg::GRID_COLS_RST;
            r_coef_x     <= hds_pkg::COEF_X_RST;
            r_coef_y     <= hds_pkg::COEF_Y_RST;
            r_step_count <= hds_pkg::STEP_COUNT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                hds_pkg::CFG_GRID_ROWS:  r_grid_rows  <= i_cfg_data[6:0];
                hds_pkg::CFG_GRID_COLS:  r_grid_cols  <= i_cfg_data[6:0];
                hds_pkg::CFG_COEF_X:     r_coef_x     <= i_cfg_data;
                hds_pkg::CFG_COEF_Y:     r_coef_y     <= i_cfg_data;
                hds_pkg::CFG_STEP_COUNT: r_step_count <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bank      <= 1'b0;
            r_i         <= '0;
            r_j         <= '0;
            r_ph        <= '0;
            r_side      <= '0;
            r_steps     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_read_value <= '0;
                        r_status     <= 1'b0;
                        case (i_req_type)
                            hds_pkg::REQ_READ: begin
                                if (addr_ok) begin
                                    r_state <= S_READ;
                                end else begin
                                    r_status    <= 1'b1;
                                    r_out_valid <= 1'b1;
                                end
                            end
                            hds_pkg::REQ_WRITE: begin
                                r_status    <= !addr_ok;
                                r_out_valid <= 1'b1;
                            end
                            hds_pkg::REQ_RUN: begin
                                if (r_step_count == '0) begin
                                    r_out_valid <= 1'b1;
                                end else begin
                                    r_steps <= r_step_count;
                                    r_i     <= RW'(1);
                                    r_j     <= CW'(1);
                                    r_ph    <= '0;
                                    r_state <= S_INT;
                                end
                            end
                            default: begin
                                r_out_valid <= 1'b1;
                            end
                        endcase
                    end
                end
                S_READ: begin
                    r_read_value <= 32'(rd_data);
                    r_out_valid  <= 1'b1;
                    r_state      <= S_IDLE;
                end
                S_INT: begin
                    if (r_ph == 3'd6) begin
                        r_ph <= '0;
                        if (r_j == nc_m2) begin
                            r_j <= CW'(1);
                            if (r_i == nr_m2) begin
                                r_i     <= '0;
                                r_j     <= '0;
                                r_side  <= 2'd0;
                                r_state <= S_BORD;
                            end else begin
                                r_i <= RW'(r_i + RW'(1));
                            end
                        end else begin
                            r_j <= CW'(r_j + CW'(1));
                        end
                    end else begin
                        r_ph <= 3'(r_ph + 3'd1);
                    end
                end
                S_BORD: begin
                    if (r_ph == 3'd0) begin
                        r_ph <= 3'd1;
                    end else begin
                        r_ph <= 3'd0;
                        case (r_side)
                            2'd0: begin
                                if (r_j == nc_m1) begin
                                    r_side <= 2'd1;
                                    r_i    <= nr_m1;
                                    r_j    <= '0;
                                end else begin
                                    r_j <= CW'(r_j + CW'(1));
                                end
                            end
                            2'd1: begin
                                if (r_j == nc_m1) begin
                                    r_side <= 2'd2;
                                    r_i    <= RW'(1);
                                    r_j    <= '0;
                                end else begin
                                    r_j <= CW'(r_j + CW'(1));
                                end
                            end
                            2'd2: begin
                                if (r_i == nr_m2) begin
                                    r_side <= 2'd3;
                                    r_i    <= RW'(1);
                                    r_j    <= nc_m1;
                                end else begin
                                    r_i <= RW'(r_i + RW'(1));
                                end
                            end
                            default: begin
                                if (r_i == nr_m2) begin
                                    r_state <= S_STEP_END;
                                end else begin
                                    r_i <= RW'(r_i + RW'(1));
                                end
                            end
                        endcase
                    end
                end
                S_STEP_END: begin
                    r_bank <= ~r_bank;
                    if (r_steps == 16'd1) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end else begin
                        r_steps <= 16'(r_steps - 16'd1);
                        r_i     <= RW'(1);
                        r_j     <= CW'(1);
                        r_ph    <= '0;
                        r_state <= S_INT;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_read_value;
    assign o_status     = r_status;

endmodule

FILE: sv/hds_checker.sv
module hds_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic [1:0]         i_req_type,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic signed [31:0] o_read_value,
    input logic               o_status
);

    // A stalled result word holds its value.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_read_value)
            && $stable(o_status))
        else $error("result word changed while stalled");

    // An address error never carries read data.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status |-> o_read_value == 32'sd0)
        else $error("error result with nonzero read value");

    // Reset leaves no result pending.
    assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A write request answers in the next cycle with zero read data.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_req_type == hds_pkg::REQ_WRITE
            |=> o_out_valid && o_read_value == 32'sd0)
        else $error("write request without prompt result");

endmodule

bind heat_diffusion_stencil_2d hds_checker u_hds_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .i_req_type   (i_req_type),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_read_value (o_read_value),
    .o_status     (o_status)
);

FILE: verif/tb_top.sv
`default_nettype none

// Testbench for the five-point heat diffusion engine.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    // Request code that the engine does not use. It must still answer with one word.
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int GRID_STRIDE = 64;
    localparam int GRID_CELLS = 64 * 64;
    // The longest silence in a correct run is one run command with the largest step count.
    // This limit is several times that.
    localparam int STALL_LIMIT = 6_000_000;
    localparam int LONG_HOLD = 400;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [1:0]         i_req_type;
    logic [5:0]         i_row;
    logic [5:0]         i_col;
    logic signed [31:0] i_cell_value;
    logic               o_out_valid;
    logic               i_out_ready;
    logic signed [31:0] o_read_value;
    logic               o_status;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index;
    logic [15:0]        i_cfg_data;

    heat_diffusion_stencil_2d dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_req_type  (i_req_type),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_cell_value(i_cell_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_read_value(o_read_value),
        .o_status    (o_status),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // One result word as the engine should return it.
    typedef struct {
        logic signed [31:0] read_value;
        logic               status;
    } t_result_word;

    // A row of the directed table. The expected word is typed in by hand.
    typedef struct {
        logic [1:0]         req;
        logic [5:0]         row;
        logic [5:0]         col;
        logic signed [31:0] value;
        logic signed [31:0] exp_value;
        logic               exp_status;
    } t_directed_row;

    // One configuration setting that a phase of random traffic runs under.
    typedef struct {
        logic [6:0]  rows;
        logic [6:0]  cols;
        logic [15:0] cx;
        logic [15:0] cy;
        logic [15:0] steps;
        int          run_pct;
        bit          big_run;
        bit          hold_output;
    } t_setting;

    // Shadow copy of the engine state. The written flags track which cells hold
    // a defined value, so that nothing ever reads or diffuses an unwritten cell.
    int          shadow_grid [2][GRID_CELLS];
    bit          shadow_written [2][GRID_CELLS];
    bit          shadow_bank;
    logic [6:0]  shadow_rows;
    logic [6:0]  shadow_cols;
    logic [15:0] shadow_cx;
    logic [15:0] shadow_cy;
    logic [15:0] shadow_steps;

    t_result_word pending_results[$];
    int           error_count;
    bit           no_gaps;
    bit           long_hold;
    int           quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int used_rows();
        if (shadow_rows < 3) return 3;
        if (shadow_rows > 64) return 64;
        return int'(shadow_rows);
    endfunction

    function automatic int used_cols();
        if (shadow_cols < 3) return 3;
        if (shadow_cols > 64) return 64;
        return int'(shadow_cols);
    endfunction

    function automatic int clip32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return int'(v);
    endfunction

    // One explicit timestep. The products are shifted arithmetically, which gives floor rounding.
    function automatic void diffuse_step(int nr, int nc);
        int cur;
        int nxt;
        int k;
        longint cc;
        longint lap_x;
        longint lap_y;
        longint sum;
        cur = int'(shadow_bank);
        nxt = int'(~shadow_bank);
        for (int i = 0; i < nr; i++) begin
            for (int j = 0; j < nc; j++) begin
                k = i * GRID_STRIDE + j;
                shadow_grid[nxt][k] = shadow_grid[cur][k];
                shadow_written[nxt][k] = 1'b1;
            end
        end
        for (int i = 1; i + 1 < nr; i++) begin
            for (int j = 1; j + 1 < nc; j++) begin
                k = i * GRID_STRIDE + j;
                cc = shadow_grid[cur][k];
                lap_x = longint'(shadow_grid[cur][k - 1]) - 2 * cc
                      + longint'(shadow_grid[cur][k + 1]);
                lap_y = longint'(shadow_grid[cur][k - GRID_STRIDE]) - 2 * cc
                      + longint'(shadow_grid[cur][k + GRID_STRIDE]);
                sum = cc + ((longint'(shadow_cx) * lap_x) >>> 16)
                    + ((longint'(shadow_cy) * lap_y) >>> 16);
                shadow_grid[nxt][k] = clip32(sum);
            end
        end
        // Edges are copied from their inner neighbors: top, left, bottom, right.
        for (int j = 1; j < nc; j++)
            shadow_grid[nxt][j] = shadow_grid[nxt][GRID_STRIDE + j];
        for (int i = 1; i < nr; i++)
            shadow_grid[nxt][i * GRID_STRIDE] = shadow_grid[nxt][i * GRID_STRIDE + 1];
        for (int j = 1; j < nc; j++)
            shadow_grid[nxt][(nr - 1) * GRID_STRIDE + j] =
                shadow_grid[nxt][(nr - 2) * GRID_STRIDE + j];
        for (int i = 1; i < nr; i++)
            shadow_grid[nxt][i * GRID_STRIDE + nc - 1] =
                shadow_grid[nxt][i * GRID_STRIDE + nc - 2];
        shadow_bank = ~shadow_bank;
    endfunction

    // Applies one accepted request to the shadow state and returns the word that it causes.
    function automatic t_result_word apply_request(logic [1:0] req, logic [5:0] r,
                                                   logic [5:0] c, logic signed [31:0] v);
        t_result_word res;
        int k;
        int nr;
        int nc;
        nr = used_rows();
        nc = used_cols();
        res.read_value = '0;
        res.status = 1'b0;
        k = int'(r) * GRID_STRIDE + int'(c);
        if (req == hds_pkg::REQ_WRITE || req == hds_pkg::REQ_READ) begin
            if (int'(r) >= nr || int'(c) >= nc) begin
                res.status = 1'b1;
            end else if (req == hds_pkg::REQ_WRITE) begin
                shadow_grid[shadow_bank][k] = v;
                shadow_written[shadow_bank][k] = 1'b1;
            end else begin
                res.read_value = shadow_grid[shadow_bank][k];
            end
        end else if (req == hds_pkg::REQ_RUN) begin
            for (int t = 0; t < int'(shadow_steps); t++)
                diffuse_step(nr, nc);
        end
        return res;
    endfunction

    // Offers one request word and waits until it is accepted. Valid is lowered only
    // when a gap follows, so it never gets two assignments in one time step.
    // If the word has a typed expectation, that word is queued in place of the
    // predicted one. The shadow state is still updated.
    task automatic send_request(logic [1:0] req, logic [5:0] r, logic [5:0] c,
                                logic signed [31:0] v, bit typed = 1'b0,
                                logic signed [31:0] exp_value = '0, logic exp_status = 1'b0);
        int gap;
        t_result_word res;
        gap = no_gaps ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_req_type   <= req;
        i_row        <= r;
        i_col        <= c;
        i_cell_value <= v;
        do @(posedge i_clk); while (!o_in_ready);
        res = apply_request(req, r, c, v);
        if (typed) begin
            res.read_value = exp_value;
            res.status = exp_status;
        end
        pending_results.push_back(res);
    endtask

    // Waits until every expected word has come back. No request is silent, so a
    // few cycles of margin are enough before the configuration is touched.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Writes all five registers back to back and keeps the shadow copy in step.
    task automatic write_setting(t_setting s);
        logic [2:0]  idx [5];
        logic [15:0] val [5];
        idx = '{hds_pkg::CFG_GRID_ROWS, hds_pkg::CFG_GRID_COLS, hds_pkg::CFG_COEF_X,
                hds_pkg::CFG_COEF_Y, hds_pkg::CFG_STEP_COUNT};
        val = '{16'(s.rows), 16'(s.cols), s.cx, s.cy, s.steps};
        for (int n = 0; n < 5; n++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[n];
            i_cfg_data  <= val[n];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
        shadow_rows  = s.rows;
        shadow_cols  = s.cols;
        shadow_cx    = s.cx;
        shadow_cy    = s.cy;
        shadow_steps = s.steps;
    endtask

    // Gives every cell in use of the current grid a defined value before a run can touch it.
    task automatic fill_grid();
        for (int i = 0; i < used_rows(); i++) begin
            for (int j = 0; j < used_cols(); j++) begin
                if (!shadow_written[shadow_bank][i * GRID_STRIDE + j])
                    send_request(hds_pkg::REQ_WRITE, 6'(i), 6'(j), $urandom);
            end
        end
    endtask

    // Picks a cell value: mostly random, sometimes an extreme.
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 32'($urandom_range(0, 20) << 16) - 32'sd655360;
            default: return $urandom;
        endcase
    endfunction

    // Random traffic under the current setting. Most requests hit the grid in use.
    // The rest miss it, use the unused code or start a run.
    task automatic random_traffic(int count, int run_pct);
        int pick;
        int nr;
        int nc;
        logic [5:0] r;
        logic [5:0] c;
        nr = used_rows();
        nc = used_cols();
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            r = 6'($urandom_range(0, nr - 1));
            c = 6'($urandom_range(0, nc - 1));
            if (pick < run_pct) begin
                send_request(hds_pkg::REQ_RUN, 6'($urandom), 6'($urandom), $urandom);
            end else if (pick < 45) begin
                send_request(hds_pkg::REQ_WRITE, r, c, pick_value());
            end else if (pick < 85) begin
                send_request(hds_pkg::REQ_READ, r, c, $urandom);
            end else if (pick < 95) begin
                // An address outside the grid in use, where the grid leaves room for one.
                if (nr < 64 && $urandom_range(0, 1) == 0)
                    r = 6'($urandom_range(nr, 63));
                else if (nc < 64)
                    c = 6'($urandom_range(nc, 63));
                send_request(($urandom_range(0, 1) == 0) ? hds_pkg::REQ_WRITE
                                                         : hds_pkg::REQ_READ,
                             r, c, $urandom);
            end else begin
                send_request(REQ_UNUSED, 6'($urandom), 6'($urandom), $urandom);
            end
        end
    endtask

    // Receiver. It stalls a random number of cycles before each word. Once in a
    // while it holds off for a long stretch, so that the engine backs up to its input.
    initial begin
        int gap;
        t_result_word want;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (long_hold) begin
                gap = LONG_HOLD;
                long_hold = 1'b0;
            end else begin
                gap = no_gaps ? 0 : $urandom_range(0, 12);
            end
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            if (pending_results.size() == 0) begin
                $display("%0t: result word with none expected: read_value %h status %b",
                         $time, o_read_value, o_status);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_read_value !== want.read_value) begin
                    $display("%0t: read_value mismatch: expected %h, actual %h",
                             $time, want.read_value, o_read_value);
                    error_count++;
                end
                if (o_status !== want.status) begin
                    $display("%0t: status mismatch: expected %b, actual %b",
                             $time, want.status, o_status);
                    error_count++;
                end
            end
        end
    end

    // Watchdog. It counts cycles in which no channel moves a word.
    initial begin
        quiet_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: timeout, nothing moved for %0d cycles", $time, quiet_cycles);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Main sequence.
    initial begin
        t_directed_row plan [16];
        t_setting      settings [8];
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_req_type   = hds_pkg::REQ_WRITE;
        i_row        = '0;
        i_col        = '0;
        i_cell_value = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = hds_pkg::CFG_GRID_ROWS;
        i_cfg_data   = '0;
        error_count  = 0;
        no_gaps      = 1'b0;
        long_hold    = 1'b0;
        shadow_bank  = 1'b0;
        shadow_rows  = hds_pkg::GRID_ROWS_RST;
        shadow_cols  = hds_pkg::GRID_COLS_RST;
        shadow_cx    = hds_pkg::COEF_X_RST;
        shadow_cy    = hds_pkg::COEF_Y_RST;
        shadow_steps = hds_pkg::STEP_COUNT_RST;
        foreach (shadow_written[b, k]) shadow_written[b][k] = 1'b0;

        // Directed part under the reset setting (64 x 64 grid): corner cells, value
        // extremes, alternating bit patterns and the unused request code.
        plan = '{
            '{hds_pkg::REQ_WRITE, 6'd0,  6'd0,  32'sh7fffffff, 32'sh0,        1'b0},
            '{hds_pkg::REQ_WRITE, 6'd63, 6'd63, 32'sh80000000, 32'sh0,        1'b0},
            '{hds_pkg::REQ_READ,  6'd0,  6'd0,  32'sh0,        32'sh7fffffff, 1'b0},
            '{hds_pkg::REQ_READ,  6'd63, 6'd63, 32'shffffffff, 32'sh80000000, 1'b0},
            '{hds_pkg::REQ_WRITE, 6'd0,  6'd63, 32'sh0,        32'sh0,        1'b0},
            '{hds_pkg::REQ_READ,  6'd0,  6'd63, 32'sh0,        32'sh0,        1'b0},
            '{hds_pkg::REQ_WRITE, 6'd63, 6'd0,  32'shffffffff, 32'sh0,        1'b0},
            '{hds_pkg::REQ_READ,  6'd63, 6'd0,  32'sh0,        32'shffffffff, 1'b0},
            '{REQ_UNUSED,         6'd63, 6'd63, 32'shffffffff, 32'sh0,        1'b0},
            '{REQ_UNUSED,         6'd0,  6'd0,  32'sh0,        32'sh0,        1'b0},
            '{hds_pkg::REQ_WRITE, 6'd21, 6'd42, 32'sh55555555, 32'sh0,        1'b0},
            '{hds_pkg::REQ_READ,  6'd21, 6'd42, 32'sh0,        32'sh55555555, 1'b0},
            '{hds_pkg::REQ_WRITE, 6'd42, 6'd21, 32'shaaaaaaaa, 32'sh0,        1'b0},
            '{hds_pkg::REQ_READ,  6'd42, 6'd21, 32'sh0,        32'shaaaaaaaa, 1'b0},
            '{hds_pkg::REQ_WRITE, 6'd0,  6'd0,  32'sh1,        32'sh0,        1'b0},
            '{hds_pkg::REQ_READ,  6'd0,  6'd0,  32'sh0,        32'sh1,        1'b0}
        };

        // Settings for the random phases. They include the smallest grid, rows and
        // columns clamped to the largest size, sizes clamped up to the smallest, both
        // coefficient extremes, a zero step count and the largest step count on the
        // smallest grid.
        settings = '{
            '{7'd3,   7'd3,   16'd0,     16'd0,     16'd1,     15, 1'b0, 1'b0},
            '{7'd0,   7'd127, 16'd65535, 16'd65535, 16'd2,     8,  1'b0, 1'b0},
            '{7'd127, 7'd1,   16'd40000, 16'd3000,  16'd2,     8,  1'b0, 1'b0},
            '{7'd5,   7'd7,   16'd12000, 16'd50000, 16'd0,     10, 1'b0, 1'b0},
            '{7'd9,   7'd6,   16'd30000, 16'd30000, 16'd4,     10, 1'b0, 1'b1},
            '{7'd3,   7'd3,   16'd65535, 16'd65535, 16'd65535, 0,  1'b1, 1'b0},
            '{7'd6,   7'd5,   16'd16384, 16'd16384, 16'd1,     10, 1'b0, 1'b0},
            '{7'd2,   7'd10,  16'd777,   16'd60000, 16'd3,     8,  1'b0, 1'b0}
        };

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[n])
            send_request(plan[n].req, plan[n].row, plan[n].col, plan[n].value, 1'b1,
                         plan[n].exp_value, plan[n].exp_status);
        wait_drained();

        foreach (settings[p]) begin
            write_setting(settings[p]);
            // Some phases run without gaps on either side.
            no_gaps = ($urandom_range(0, 3) == 0);
            fill_grid();
            if (settings[p].hold_output) long_hold = 1'b1;
            if (settings[p].big_run) send_request(hds_pkg::REQ_RUN, '0, '0, '0);
            random_traffic(20, settings[p].run_pct);
            wait_drained();
        end

        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
sv/hds_pkg.sv
sv/heat_diffusion_stencil_2d.sv
sv/hds_checker.sv
verif/tb_top.sv
